### design/mclb_pkg.sv
// Package for the multi-channel LED blinker: command/result types, kind codes, widths.
// No dependencies; used by the interfaces and all blinker modules.
`default_nettype none

package mclb_pkg;

    localparam int MAX_LEDS     = 8;
    localparam int NUM_LEDS_DEF = 8;
    localparam int CHAN_W       = 3;
    localparam int KIND_W       = 2;
    localparam int DUR_W        = 16;
    localparam int MS_W         = 32;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLASH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic              level;
        logic              notify;
        logic [DUR_W-1:0]  blink_count;
        logic [DUR_W-1:0]  on_ms;
        logic [DUR_W-1:0]  off_ms;
    } cmd_t;

    // Millisecond time seen by the channels for one command
    typedef struct packed {
        logic [MS_W-1:0] now;      // counter before this command
        logic [MS_W-1:0] now_inc;  // counter after a tick
    } ms_time_t;

    // Per-channel state: current level, and level and blinking flag after the command
    typedef struct packed {
        logic level_cur;
        logic level_nxt;
        logic active_nxt;
    } chan_stat_t;

    typedef struct packed {
        logic [MAX_LEDS-1:0] led_levels;
        logic [MAX_LEDS-1:0] blinking_mask;
        logic                change_event;
        logic [CHAN_W-1:0]   event_channel;
        logic                event_level;
    } res_t;

endpackage

`default_nettype wire

### design/mclb_cmd_if.sv
// Command channel interface (valid/ready plus command fields).
// Depends on mclb_pkg.
`default_nettype none

interface mclb_cmd_if
    import mclb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] channel;
    logic              level;
    logic              notify;
    logic [DUR_W-1:0]  blink_count;
    logic [DUR_W-1:0]  on_ms;
    logic [DUR_W-1:0]  off_ms;

    modport source (
        output valid, kind, channel, level, notify, blink_count, on_ms, off_ms,
        input  ready
    );
    modport sink (
        input  valid, kind, channel, level, notify, blink_count, on_ms, off_ms,
        output ready
    );
endinterface

`default_nettype wire

### design/mclb_res_if.sv
// Result channel interface (valid/ready plus result fields).
// Depends on mclb_pkg.
`default_nettype none

interface mclb_res_if
    import mclb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MAX_LEDS-1:0] led_levels;
    logic [MAX_LEDS-1:0] blinking_mask;
    logic                change_event;
    logic [CHAN_W-1:0]   event_channel;
    logic                event_level;

    modport source (
        output valid, led_levels, blinking_mask, change_event, event_channel, event_level,
        input  ready
    );
    modport sink (
        input  valid, led_levels, blinking_mask, change_event, event_channel, event_level,
        output ready
    );
endinterface

`default_nettype wire

### design/multi_channel_led_blinker_top.sv
// Multi-channel LED blinker top level: input register, channel array, ms counter, result register.
// Depends on mclb_pkg, mclb_cmd_if, mclb_res_if, mclb_in_reg, mclb_channel.
//
// Usage:
//   cmd: valid/ready command channel. kind selects set level, start flashing or a
//        one millisecond tick; channel, level, notify, blink_count, on_ms, off_ms
//        carry the operands.
//   res: valid/ready result channel, exactly one result transaction per command:
//        all LED levels, the mask of blinking channels and an optional change event
//        for a notified set.
//   cfg_we/cfg_wdata: writes callback_enabled; write only while no command is in flight.
// Pipeline: a command taken into the input register has its result loaded into the
//   result register when it advances, with res.valid high from then on until taken.
//   Throughput: one command per cycle while res.ready stays high; every channel
//   does its 32-bit elapsed subtract and compare in parallel.
// Reset: all LEDs off, no channel blinking, millisecond counter zero,
//   callback_enabled off, both pipeline registers empty.
// Stall: when res.ready is low, a held result stays in the result register; the input
//   register takes a command only while empty, then cmd.ready drops until res.ready returns.
`default_nettype none

module multi_channel_led_blinker_top
    import mclb_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    mclb_cmd_if.sink  cmd,
    mclb_res_if.source res
);

    logic                s1_valid;
    cmd_t                s1_cmd;
    logic                advance;
    logic                cb_reg;
    logic [MS_W-1:0]     now_reg, now_next;
    ms_time_t            tm;
    logic [MAX_LEDS-1:0] lvl_cur, lvl_nxt, act_nxt;
    logic                ch_valid;
    logic                ev;
    logic                out_valid_reg, out_valid_next;
    res_t                res_reg, res_next;

    // Input register
    mclb_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .advance (advance),
        .valid   (s1_valid),
        .cmd_out (s1_cmd)
    );

    // Held command proceeds when the result register is free or being emptied
    assign advance = s1_valid && (!out_valid_reg || res.ready);

    // Millisecond counter
    assign tm       = '{now: now_reg, now_inc: now_reg + MS_W'(1)};
    assign now_next = (s1_cmd.kind == KIND_TICK) ? tm.now_inc : now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            cb_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                now_reg <= now_next;
            end
            if (cfg_we)
            begin
                cb_reg <= cfg_wdata;
            end
        end
    end

    // Channel array; unused positions read as off
    for (genvar i = 0; i < MAX_LEDS; i++)
    begin : g_chan
        if (i < NUM_LEDS)
        begin : g_on
            chan_stat_t stat;
            mclb_channel #(.IDX(i)) u_chan (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .cmd     (s1_cmd),
                .tm      (tm),
                .stat    (stat)
            );
            assign lvl_cur[i] = stat.level_cur;
            assign lvl_nxt[i] = stat.level_nxt;
            assign act_nxt[i] = stat.active_nxt;
        end
        else
        begin : g_off
            assign lvl_cur[i] = 1'b0;
            assign lvl_nxt[i] = 1'b0;
            assign act_nxt[i] = 1'b0;
        end
    end

    // Notified level change on a set command
    assign ch_valid = ({1'b0, s1_cmd.channel} < (CHAN_W+1)'(NUM_LEDS));
    assign ev = (s1_cmd.kind == KIND_SET) && ch_valid && s1_cmd.notify && cb_reg
                && (lvl_cur[s1_cmd.channel] != s1_cmd.level);

    assign res_next = '{led_levels:    lvl_nxt,
                        blinking_mask: act_nxt,
                        change_event:  ev,
                        event_channel: ev ? s1_cmd.channel : '0,
                        event_level:   ev && s1_cmd.level};

    // Result register
    assign out_valid_next = advance || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.led_levels    = res_reg.led_levels;
    assign res.blinking_mask = res_reg.blinking_mask;
    assign res.change_event  = res_reg.change_event;
    assign res.event_channel = res_reg.event_channel;
    assign res.event_level   = res_reg.event_level;

endmodule

`default_nettype wire

### design/mclb_in_reg.sv
// Input register stage: captures one command transaction per cycle while empty or advancing.
// Depends on mclb_pkg and mclb_cmd_if.
`default_nettype none

module mclb_in_reg
    import mclb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mclb_cmd_if.sink    cmd,
    input  wire logic   advance,   // held command is consumed this cycle
    output logic        valid,
    output cmd_t        cmd_out
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;

    // Free when empty or when the held command moves on
    assign cmd.ready  = !valid_reg || advance;
    assign valid_next = (cmd.valid && cmd.ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= '{kind: cmd.kind, channel: cmd.channel, level: cmd.level,
                         notify: cmd.notify, blink_count: cmd.blink_count,
                         on_ms: cmd.on_ms, off_ms: cmd.off_ms};
        end
    end

    assign valid   = valid_reg;
    assign cmd_out = cmd_reg;

endmodule

`default_nettype wire

### design/mclb_channel.sv
// One LED channel: level, blink arming and on/off timing, updated per command.
// Depends on mclb_pkg.
`default_nettype none

module mclb_channel
    import mclb_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     advance,
    input  wire cmd_t     cmd,
    input  wire ms_time_t tm,
    output chan_stat_t    stat
);

    logic             level_reg, level_next;
    logic             active_reg, active_next;
    logic [MS_W-1:0]  start_reg, start_next;
    logic [DUR_W-1:0] on_reg, on_next;
    logic [DUR_W-1:0] off_reg, off_next;
    logic [DUR_W-1:0] done_reg, done_next;
    logic [DUR_W-1:0] target_reg, target_next;
    logic             hit;
    logic [MS_W-1:0]  elapsed;

    assign hit     = (cmd.channel == CHAN_W'(IDX));
    assign elapsed = tm.now_inc - start_reg;

    // Next-state logic for one command
    always_comb
    begin
        level_next  = level_reg;
        active_next = active_reg;
        start_next  = start_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        done_next   = done_reg;
        target_next = target_reg;
        case (cmd.kind)
            KIND_SET:
            begin
                if (hit)
                begin
                    if (!cmd.level)
                    begin
                        active_next = 1'b0;
                    end
                    level_next = cmd.level;
                end
            end
            KIND_FLASH:
            begin
                if (hit)
                begin
                    active_next = 1'b1;
                    start_next  = tm.now;
                    on_next     = cmd.on_ms;
                    off_next    = cmd.off_ms;
                    done_next   = '0;
                    target_next = cmd.blink_count;
                end
            end
            KIND_TICK:
            begin
                if (active_reg)
                begin
                    if (done_reg >= target_reg)
                    begin
                        active_next = 1'b0;
                    end
                    else if (!level_reg)
                    begin
                        if (elapsed >= {{(MS_W-DUR_W){1'b0}}, off_reg})
                        begin
                            level_next = 1'b1;
                            start_next = tm.now_inc;
                        end
                    end
                    else if (elapsed >= {{(MS_W-DUR_W){1'b0}}, on_reg})
                    begin
                        level_next = 1'b0;
                        start_next = tm.now_inc;
                        done_next  = done_reg + DUR_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (advance)
        begin
            level_reg  <= level_next;
            active_reg <= active_next;
        end
    end

    // Blink timing payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            start_reg  <= start_next;
            on_reg     <= on_next;
            off_reg    <= off_next;
            done_reg   <= done_next;
            target_reg <= target_next;
        end
    end

    assign stat = '{level_cur: level_reg, level_nxt: level_next, active_nxt: active_next};

endmodule

`default_nettype wire

### verif/tb_multi_channel_led_blinker_top.sv
// Testbench for multi_channel_led_blinker_top: sends set, flash and tick commands with random
// gaps and result stalls, and checks each status transaction against a channel model.
// Depends on mclb_pkg, mclb_cmd_if, mclb_res_if and the blinker RTL.

module tb_multi_channel_led_blinker_top;
    import mclb_pkg::*;

    // Kind code the block ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Channel model plus the queue of status transactions still owed by the block
    class led_scoreboard;
        bit             listen_en;
        bit             lit[MAX_LEDS];
        bit             armed[MAX_LEDS];
        bit [MS_W-1:0]  ms_now;
        bit [MS_W-1:0]  phase_start[MAX_LEDS];
        bit [DUR_W-1:0] on_len[MAX_LEDS];
        bit [DUR_W-1:0] off_len[MAX_LEDS];
        bit [DUR_W-1:0] blinks_done[MAX_LEDS];
        bit [DUR_W-1:0] blinks_goal[MAX_LEDS];
        res_t           expected_status[$];
        int             n_bad;
        int             n_checked;
        int             n_events;
        int             n_sets;
        int             n_flashes;
        int             n_ticks;
        int             n_ignored;

        // Update the channels for one accepted command and queue the status it yields
        function void apply_command(cmd_t c);
            res_t          st;
            int unsigned   ch;
            bit [MS_W-1:0] elapsed;
            st = '0;
            ch = 32'(c.channel);
            if (c.kind == KIND_SET)
            begin
                n_sets++;
                // off always cancels the sequence, even with no level change
                if (!c.level)
                    armed[ch] = 1'b0;
                if (lit[ch] != c.level)
                begin
                    lit[ch] = c.level;
                    if (c.notify && listen_en)
                    begin
                        st.change_event  = 1'b1;
                        st.event_channel = c.channel;
                        st.event_level   = c.level;
                    end
                end
            end
            else if (c.kind == KIND_FLASH)
            begin
                n_flashes++;
                armed[ch]       = 1'b1;
                phase_start[ch] = ms_now;
                on_len[ch]      = c.on_ms;
                off_len[ch]     = c.off_ms;
                blinks_done[ch] = '0;
                blinks_goal[ch] = c.blink_count;
            end
            else if (c.kind == KIND_TICK)
            begin
                n_ticks++;
                ms_now++;
                for (int i = 0; i < MAX_LEDS; i++)
                begin
                    elapsed = ms_now - phase_start[i];
                    if (!armed[i])
                        ;
                    else if (blinks_done[i] >= blinks_goal[i])
                        armed[i] = 1'b0;        // finished: level stays as it is
                    else if (!lit[i])
                    begin
                        if (elapsed >= off_len[i])
                        begin
                            lit[i]         = 1'b1;
                            phase_start[i] = ms_now;
                        end
                    end
                    else if (elapsed >= on_len[i])
                    begin
                        lit[i]         = 1'b0;
                        phase_start[i] = ms_now;
                        blinks_done[i] = blinks_done[i] + DUR_W'(1);
                    end
                end
            end
            else
                n_ignored++;
            for (int i = 0; i < MAX_LEDS; i++)
            begin
                st.led_levels[i]    = lit[i];
                st.blinking_mask[i] = armed[i];
            end
            expected_status.push_back(st);
        endfunction

        // Compare one status transaction with the oldest one owed
        function void check_status(res_t got);
            res_t want;
            if (expected_status.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("status with nothing pending: levels %h mask %h event %b/%0d/%b",
                             got.led_levels, got.blinking_mask, got.change_event,
                             got.event_channel, got.event_level);
                return;
            end
            want = expected_status.pop_front();
            n_checked++;
            if (got.change_event === 1'b1)
                n_events++;
            if (got.led_levels !== want.led_levels || got.blinking_mask !== want.blinking_mask
                || got.change_event !== want.change_event
                || got.event_channel !== want.event_channel
                || got.event_level !== want.event_level)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display({"status %0d: expected levels %h mask %h event %b/%0d/%b, ",
                              "got %h %h %b/%0d/%b"},
                             n_checked, want.led_levels, want.blinking_mask, want.change_event,
                             want.event_channel, want.event_level, got.led_levels,
                             got.blinking_mask, got.change_event, got.event_channel,
                             got.event_level);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    bit   idle_on;
    int   stall_left;
    int   n_cfg_writes;

    led_scoreboard sb = new;

    mclb_cmd_if cmd_ch ();
    mclb_res_if res_ch ();

    multi_channel_led_blinker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // 10 unit clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watch both channels at the rising edge
    always @(posedge clk)
    begin
        cmd_t seen_cmd;
        res_t seen_res;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen_cmd.kind        = cmd_ch.kind;
                seen_cmd.channel     = cmd_ch.channel;
                seen_cmd.level       = cmd_ch.level;
                seen_cmd.notify      = cmd_ch.notify;
                seen_cmd.blink_count = cmd_ch.blink_count;
                seen_cmd.on_ms       = cmd_ch.on_ms;
                seen_cmd.off_ms      = cmd_ch.off_ms;
                sb.apply_command(seen_cmd);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                seen_res.led_levels    = res_ch.led_levels;
                seen_res.blinking_mask = res_ch.blinking_mask;
                seen_res.change_event  = res_ch.change_event;
                seen_res.event_channel = res_ch.event_channel;
                seen_res.event_level   = res_ch.event_level;
                sb.check_status(seen_res);
                stall_left = idle_on ? $urandom_range(0, 4) : 0;
            end
        end
    end

    // Result side: hold ready low for the drawn number of cycles after each transaction
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else
            res_ch.ready <= 1'b1;
    end

    function automatic cmd_t make_cmd(logic [KIND_W-1:0] kind, int unsigned ch,
                                      int unsigned lvl, int unsigned ntf, int unsigned cnt,
                                      int unsigned on_t, int unsigned off_t);
        cmd_t c;
        c.kind        = kind;
        c.channel     = ch[CHAN_W-1:0];
        c.level       = lvl[0];
        c.notify      = ntf[0];
        c.blink_count = cnt[DUR_W-1:0];
        c.on_ms       = on_t[DUR_W-1:0];
        c.off_ms      = off_t[DUR_W-1:0];
        return c;
    endfunction

    // Present one command after a random gap and hold it until accepted
    task automatic send_cmd(cmd_t c);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.kind        <= c.kind;
        cmd_ch.channel     <= c.channel;
        cmd_ch.level       <= c.level;
        cmd_ch.notify      <= c.notify;
        cmd_ch.blink_count <= c.blink_count;
        cmd_ch.on_ms       <= c.on_ms;
        cmd_ch.off_ms      <= c.off_ms;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and let every owed status come back
    task automatic wait_idle();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_listen(bit v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.listen_en = v;
        n_cfg_writes++;
    endtask

    // Run limit
    initial
    begin
        #2000000;
        $display("tb_multi_channel_led_blinker_top NOT OK");
        $finish;
    end

    initial
    begin
        cmd_t        c;
        bit [63:0]   rnd;
        int          n_real;
        int unsigned pick;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.kind        = KIND_SET;
        cmd_ch.channel     = '0;
        cmd_ch.level       = 1'b0;
        cmd_ch.notify      = 1'b0;
        cmd_ch.blink_count = '0;
        cmd_ch.on_ms       = '0;
        cmd_ch.off_ms      = '0;
        res_ch.ready       = 1'b0;
        idle_on            = 1'b1;
        stall_left         = 0;
        n_cfg_writes       = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: notify with no listener, then with one
        write_listen(1'b0);
        send_cmd(make_cmd(KIND_SET, 0, 1, 1, 0, 0, 0));
        send_cmd(make_cmd(KIND_SET, 0, 0, 1, 0, 0, 0));
        wait_idle();
        write_listen(1'b1);
        send_cmd(make_cmd(KIND_SET, 7, 1, 1, 0, 0, 0));
        send_cmd(make_cmd(KIND_SET, 7, 1, 1, 0, 0, 0));        // same level: silent
        send_cmd(make_cmd(KIND_SET, 7, 0, 0, 0, 0, 0));        // change without notify
        send_cmd(make_cmd(KIND_SET, 3, 1, 1, 0, 0, 0));
        send_cmd(make_cmd(KIND_FLASH, 3, 0, 0, 2, 1, 1));      // flash keeps level
        send_cmd(make_cmd(KIND_SET, 3, 1, 1, 0, 0, 0));        // on while blinking stays armed
        send_cmd(make_cmd(KIND_FLASH, 5, 0, 0, 0, 'hFFFF, 'hFFFF));  // zero count
        send_cmd(make_cmd(KIND_FLASH, 1, 1, 1, 'hFFFF, 'hFFFF, 0));
        send_cmd(make_cmd(KIND_FLASH, 2, 0, 0, 1, 0, 0));
        repeat (6)
            send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_SET, 1, 0, 1, 0, 0, 0));        // cancel, level already on
        send_cmd(make_cmd(KIND_SET, 1, 0, 1, 0, 0, 0));        // off while off still cancels
        send_cmd(make_cmd(KIND_UNUSED, 7, 1, 1, 'hFFFF, 'hFFFF, 'hFFFF));
        send_cmd(make_cmd(KIND_FLASH, 6, 0, 0, 3, 2, 1));
        send_cmd(make_cmd(KIND_TICK, 7, 1, 1, 'hFFFF, 'hFFFF, 'hFFFF));
        send_cmd(make_cmd(KIND_FLASH, 6, 1, 0, 1, 0, 0));      // re-arm restarts
        send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));

        // Random phases, alternating the listener, with idling off in the second phase
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            write_listen(ph[0]);
            idle_on = (ph != 1);
            n_real  = 0;
            while (n_real < 170)
            begin
                rnd  = {$urandom, $urandom};
                c    = rnd[$bits(cmd_t)-1:0];
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    c.kind = KIND_TICK;
                else if (pick < 72)
                    c.kind = KIND_SET;
                else if (pick < 90)
                begin
                    // short sequences that run to completion
                    c.kind        = KIND_FLASH;
                    c.blink_count = DUR_W'($urandom_range(0, 3));
                    c.on_ms       = DUR_W'($urandom_range(0, 4));
                    c.off_ms      = DUR_W'($urandom_range(0, 4));
                end
                else if (pick < 95)
                    c.kind = KIND_FLASH;
                else
                    c.kind = KIND_UNUSED;
                if (c.kind != KIND_UNUSED)
                    n_real++;
                send_cmd(c);
            end
        end
        wait_idle();

        $display("ran %0d set, %0d flash, %0d tick and %0d ignored commands, %0d listener writes",
                 sb.n_sets, sb.n_flashes, sb.n_ticks, sb.n_ignored, n_cfg_writes);
        $display("checked %0d status transactions, %0d notified changes, %0d mismatches",
                 sb.n_checked, sb.n_events, sb.n_bad);
        if (sb.n_bad == 0 && sb.expected_status.size() == 0)
            $display("tb_multi_channel_led_blinker_top OK");
        else
            $display("tb_multi_channel_led_blinker_top NOT OK");
        $finish;
    end

endmodule
